// ===== sv/dsar_pkg.sv =====
// Shared types, codes and helper functions for the security access responder.
package dsar_pkg;

	// Phase of the frame parser.
	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_KEY     = 2'd1,
		PH_ROUTINE = 2'd2,
		PH_SKIP    = 2'd3
	} phase_t;

	// Security access level; the fourth code is never produced.
	typedef enum logic [1:0] {
		LVL_LOCKED   = 2'd0,
		LVL_WAITING  = 2'd1,
		LVL_UNLOCKED = 2'd2
	} level_t;

	// Response codes carried on the result channel.
	typedef enum logic [2:0] {
		RESP_SEED_SENT   = 3'd0,
		RESP_KEY_OK      = 3'd1,
		RESP_KEY_BAD     = 3'd2,
		RESP_ROUTINE_OK  = 3'd3,
		RESP_ROUTINE_BAD = 3'd4
	} resp_t;

	// Configuration register indexes.
	localparam logic CFG_ROUTINE_ID = 1'b0;
	localparam logic CFG_KEY_ADDEND = 1'b1;

	// Header words and framing characters.
	localparam logic [31:0] HDR_SEED    = 32'h3237_3031;
	localparam logic [31:0] HDR_KEY     = 32'h3237_3032;
	localparam logic [31:0] HDR_ROUTINE = 32'h3331_3031;
	localparam logic [7:0]  CHAR_CR     = 8'd13;

	// Register reset values.
	localparam logic [31:0] ROUTINE_ID_RST = 32'h4141_3030;
	localparam logic [7:0]  KEY_ADDEND_RST = 8'd1;

	// One step result handed from the engine to the output register.
	typedef struct packed {
		logic        valid;
		resp_t       response;
		logic [31:0] seed;
		logic        led;
	} result_t;

	// Hex digit decode: bit 4 set flags a character that is not a hex digit.
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [4:0] r;
		r = 5'h10;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b0, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b0, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b0, 4'(c - 8'h57)};
		end
		return r;
	endfunction

	// Byte of a 32-bit word, byte 0 in the top bits.
	function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0: b = w[31:24];
			2'd1: b = w[23:16];
			2'd2: b = w[15:8];
			default: b = w[7:0];
		endcase
		return b;
	endfunction

endpackage

// ===== sv/dsar_engine.sv =====
// Frame parser and seed/key state machine; one character per enabled cycle.
module dsar_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step_en,
	input  logic [7:0]         rx_char,
	input  logic [31:0]        entropy_word,
	input  logic [31:0]        routine_id,
	input  logic [7:0]         key_addend,
	output dsar_pkg::result_t  result
);

	dsar_pkg::phase_t phase_q, phase_d;
	dsar_pkg::level_t level_q, level_d;
	logic [2:0]  cnt_q, cnt_d;
	logic [31:0] header_q, header_d;
	logic [31:0] exp_key_q, exp_key_d;
	logic [7:0]  accum_q, accum_d;
	logic        pair_bad_q, pair_bad_d;
	logic        mismatch_q, mismatch_d;
	logic        led_q, led_d;

	logic [31:0] hdr_word;
	logic [4:0]  nib;
	logic [7:0]  accum_new;
	logic        pair_bad_new;
	logic [7:0]  key_got;
	logic        mismatch_new;

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= dsar_pkg::PH_HEADER;
			level_q    <= dsar_pkg::LVL_LOCKED;
			cnt_q      <= '0;
			header_q   <= '0;
			exp_key_q  <= '0;
			accum_q    <= '0;
			pair_bad_q <= 1'b0;
			mismatch_q <= 1'b0;
			led_q      <= 1'b0;
		end else if (step_en) begin
			phase_q    <= phase_d;
			level_q    <= level_d;
			cnt_q      <= cnt_d;
			header_q   <= header_d;
			exp_key_q  <= exp_key_d;
			accum_q    <= accum_d;
			pair_bad_q <= pair_bad_d;
			mismatch_q <= mismatch_d;
			led_q      <= led_d;
		end
	end

	assign hdr_word = {header_q[23:0], rx_char};
	assign nib      = dsar_pkg::hex_nibble(rx_char);

	// Key digit accumulation and per-pair comparison.
	always_comb begin
		accum_new    = nib[4] ? accum_q : {accum_q[3:0], nib[3:0]};
		pair_bad_new = pair_bad_q | nib[4];
		key_got      = pair_bad_new ? 8'd0 : accum_new;
		mismatch_new = mismatch_q;
		if (cnt_q[0] && key_got != dsar_pkg::word_byte(exp_key_q, cnt_q[2:1])) begin
			mismatch_new = 1'b1;
		end
	end

	// Next state and result for the current character.
	always_comb begin
		phase_d    = phase_q;
		level_d    = level_q;
		cnt_d      = cnt_q + 3'd1;
		header_d   = header_q;
		exp_key_d  = exp_key_q;
		accum_d    = accum_q;
		pair_bad_d = pair_bad_q;
		mismatch_d = mismatch_q;
		led_d      = led_q;
		result.valid    = 1'b0;
		result.response = dsar_pkg::RESP_SEED_SENT;
		result.seed     = '0;

		case (phase_q)
			dsar_pkg::PH_HEADER: begin
				header_d = hdr_word;
				if (cnt_q[1:0] == 2'd3) begin
					cnt_d      = '0;
					mismatch_d = 1'b0;
					accum_d    = '0;
					pair_bad_d = 1'b0;
					phase_d    = dsar_pkg::PH_SKIP;
					if (hdr_word == dsar_pkg::HDR_SEED && level_q == dsar_pkg::LVL_LOCKED) begin
						exp_key_d = {entropy_word[31:24] + key_addend,
							entropy_word[23:16] + key_addend,
							entropy_word[15:8] + key_addend,
							entropy_word[7:0] + key_addend};
						level_d         = dsar_pkg::LVL_WAITING;
						result.valid    = 1'b1;
						result.response = dsar_pkg::RESP_SEED_SENT;
						result.seed     = entropy_word;
					end else if (hdr_word == dsar_pkg::HDR_KEY &&
						level_q == dsar_pkg::LVL_WAITING) begin
						phase_d = dsar_pkg::PH_KEY;
					end else if (hdr_word == dsar_pkg::HDR_ROUTINE) begin
						phase_d = dsar_pkg::PH_ROUTINE;
					end
				end
			end
			dsar_pkg::PH_KEY: begin
				mismatch_d = mismatch_new;
				if (cnt_q[0]) begin
					accum_d    = '0;
					pair_bad_d = 1'b0;
				end else begin
					accum_d    = accum_new;
					pair_bad_d = pair_bad_new;
				end
				if (cnt_q == 3'd7) begin
					cnt_d        = '0;
					phase_d      = dsar_pkg::PH_SKIP;
					result.valid = 1'b1;
					if (!mismatch_new) begin
						level_d         = dsar_pkg::LVL_UNLOCKED;
						result.response = dsar_pkg::RESP_KEY_OK;
					end else begin
						level_d         = dsar_pkg::LVL_LOCKED;
						result.response = dsar_pkg::RESP_KEY_BAD;
					end
				end
			end
			dsar_pkg::PH_ROUTINE: begin
				if (rx_char != dsar_pkg::word_byte(routine_id, cnt_q[1:0])) begin
					mismatch_d = 1'b1;
				end
				if (cnt_q[1:0] == 2'd3) begin
					cnt_d        = '0;
					phase_d      = dsar_pkg::PH_SKIP;
					result.valid = 1'b1;
					if (level_q == dsar_pkg::LVL_UNLOCKED && !mismatch_d) begin
						led_d           = 1'b1;
						result.response = dsar_pkg::RESP_ROUTINE_OK;
					end else begin
						result.response = dsar_pkg::RESP_ROUTINE_BAD;
					end
				end
			end
			default: begin
				cnt_d = cnt_q;
				if (rx_char == dsar_pkg::CHAR_CR) begin
					phase_d  = dsar_pkg::PH_HEADER;
					cnt_d    = '0;
					header_d = '0;
				end
			end
		endcase

		result.led = led_d;
	end

endmodule

// ===== sv/diag_security_access_responder_core.sv =====
// Top level of the diagnostic security access responder.
//
// Usage: request characters arrive on the input channel (in_valid, in_stall,
// rx_char, entropy_word), one character per request. entropy_word is used only
// with the fourth header character of a seed request. Responses leave on the
// output channel (out_valid, out_stall, response, seed_out, led_on); most
// characters produce no response. routine_id and key_addend are written on
// the configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data),
// which is always ready; write it only while the block is idle.
// Path: a character is captured in the input register, stepped through the
// engine from there, and its response is captured in the output register.
// Throughput: one character per cycle while no response waits under out_stall;
// the frame parser updates its state once per character.
// Reset: arst_n clears the parser to the header phase, the access level to
// locked, the LED latch, both pipeline valids and the registers to their
// defaults ("AA00" and an addend of one).
// Stall: while a response waits under out_stall, the input register still
// takes one more character; after that in_stall rises until the response
// is taken.
module diag_security_access_responder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_char,
	input  logic [31:0] entropy_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  response,
	output logic [31:0] seed_out,
	output logic        led_on,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	logic [31:0] routine_id_q;
	logic [7:0]  key_addend_q;
	logic        valid_s1;
	logic [7:0]  rx_char_s1;
	logic [31:0] entropy_s1;
	logic        out_valid_q;
	logic [2:0]  response_q;
	logic [31:0] seed_q;
	logic        led_q;
	logic        out_free;
	logic        s1_free;
	logic        step_en;
	dsar_pkg::result_t res;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			routine_id_q <= dsar_pkg::ROUTINE_ID_RST;
			key_addend_q <= dsar_pkg::KEY_ADDEND_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dsar_pkg::CFG_ROUTINE_ID: routine_id_q <= cfg_data;
				dsar_pkg::CFG_KEY_ADDEND: key_addend_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Flow control between input register and output register.
	assign out_free = !out_valid_q || !out_stall;
	assign step_en  = valid_s1 && out_free;
	assign s1_free  = !valid_s1 || out_free;
	assign in_stall = !s1_free;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && s1_free) begin
			rx_char_s1 <= rx_char;
			entropy_s1 <= entropy_word;
		end
	end

	dsar_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_en      (step_en),
		.rx_char      (rx_char_s1),
		.entropy_word (entropy_s1),
		.routine_id   (routine_id_q),
		.key_addend   (key_addend_q),
		.result       (res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_en) begin
			out_valid_q <= res.valid;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && res.valid) begin
			response_q <= res.response;
			seed_q     <= res.seed;
			led_q      <= res.led;
		end
	end

	assign out_valid = out_valid_q;
	assign response  = response_q;
	assign seed_out  = seed_q;
	assign led_on    = led_q;

endmodule

// ===== sv/dsar_checker.sv =====
// Port-level checker for the security access responder, with its bind.
module dsar_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  response,
	input logic [31:0] seed_out,
	input logic        led_on
);

	// A stalled response keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(response) && $stable(seed_out))
		else $error("stalled response changed");

	// Only the five defined response codes appear.
	a_resp_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> response <= dsar_pkg::RESP_ROUTINE_BAD)
		else $error("undefined response code");

	// Seed bytes are reported only with a seed response.
	a_seed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && response != dsar_pkg::RESP_SEED_SENT |-> seed_out == 32'd0)
		else $error("seed field set on a non-seed response");

	// A started routine always shows the LED latched.
	a_led_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && response == dsar_pkg::RESP_ROUTINE_OK |-> led_on)
		else $error("routine started without LED latch");

endmodule

bind diag_security_access_responder_core dsar_checker u_dsar_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.response  (response),
	.seed_out  (seed_out),
	.led_on    (led_on)
);

// ===== dv/diag_security_access_responder_core_tb.sv =====
// Self-checking testbench for the diagnostic security access responder core.
module diag_security_access_responder_core_tb;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_CHARS   = 470;
	localparam int HOLD_CYCLES   = 200;

	// One response as the block should present it.
	typedef struct {
		dsar_pkg::resp_t response;
		logic [31:0]     seed;
		logic            led;
	} reply_t;

	// Tracks the responder state and checks the responses it produces.
	class access_scoreboard;
		logic [31:0]      routine_id;
		logic [7:0]       key_addend;
		dsar_pkg::phase_t phase;
		logic [3:0]       count;
		logic [31:0]      header;
		dsar_pkg::level_t level;
		logic [31:0]      key;
		logic [7:0]       accum;
		logic             pair_bad;
		logic             mismatch;
		logic             led;
		reply_t           pending[$];
		int               errors;
		int               seen[5];

		function new();
			routine_id = dsar_pkg::ROUTINE_ID_RST;
			key_addend = dsar_pkg::KEY_ADDEND_RST;
			phase = dsar_pkg::PH_HEADER;
			count = '0;
			header = '0;
			level = dsar_pkg::LVL_LOCKED;
			key = '0;
			accum = '0;
			pair_bad = 1'b0;
			mismatch = 1'b0;
			led = 1'b0;
			errors = 0;
			foreach (seen[i]) seen[i] = 0;
		endfunction

		// Returns the value of a hex digit, or -1 for any other character.
		function int hex_value(logic [7:0] c);
			if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
			if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h37;
			if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h57;
			return -1;
		endfunction

		function void write_reg(logic idx, logic [31:0] data);
			if (idx == dsar_pkg::CFG_ROUTINE_ID) routine_id = data;
			else key_addend = data[7:0];
		endfunction

		function void push(dsar_pkg::resp_t r, logic [31:0] s);
			reply_t x;
			x.response = r;
			x.seed = s;
			x.led = led;
			pending.push_back(x);
		endfunction

		// Advances the parser by one accepted character.
		function void take_char(logic [7:0] c, logic [31:0] ent);
			int nib;
			int sel;
			logic [7:0] got;
			logic [7:0] want;
			case (phase)
				dsar_pkg::PH_HEADER: begin
					header = {header[23:0], c};
					count = count + 4'd1;
					if (count >= 4'd4) begin
						count = '0;
						mismatch = 1'b0;
						accum = '0;
						pair_bad = 1'b0;
						phase = dsar_pkg::PH_SKIP;
						if (header == dsar_pkg::HDR_SEED && level == dsar_pkg::LVL_LOCKED) begin
							for (int i = 0; i < 4; i++) begin
								key[8*i +: 8] = ent[8*i +: 8] + key_addend;
							end
							level = dsar_pkg::LVL_WAITING;
							push(dsar_pkg::RESP_SEED_SENT, ent);
						end else if (header == dsar_pkg::HDR_KEY &&
							level == dsar_pkg::LVL_WAITING) begin
							phase = dsar_pkg::PH_KEY;
						end else if (header == dsar_pkg::HDR_ROUTINE) begin
							phase = dsar_pkg::PH_ROUTINE;
						end
					end
				end
				dsar_pkg::PH_KEY: begin
					nib = hex_value(c);
					if (nib < 0) pair_bad = 1'b1;
					else accum = {accum[3:0], nib[3:0]};
					// A pair holding any non-hex character reads as zero.
					if (count[0]) begin
						sel = 3 - int'(count[2:1]);
						got = pair_bad ? 8'h00 : accum;
						want = key[8*sel +: 8];
						if (got != want) mismatch = 1'b1;
						accum = '0;
						pair_bad = 1'b0;
					end
					count = count + 4'd1;
					if (count >= 4'd8) begin
						count = '0;
						phase = dsar_pkg::PH_SKIP;
						if (!mismatch) begin
							level = dsar_pkg::LVL_UNLOCKED;
							push(dsar_pkg::RESP_KEY_OK, '0);
						end else begin
							level = dsar_pkg::LVL_LOCKED;
							push(dsar_pkg::RESP_KEY_BAD, '0);
						end
					end
				end
				dsar_pkg::PH_ROUTINE: begin
					sel = 3 - int'(count[1:0]);
					want = routine_id[8*sel +: 8];
					if (c != want) mismatch = 1'b1;
					count = count + 4'd1;
					if (count >= 4'd4) begin
						count = '0;
						phase = dsar_pkg::PH_SKIP;
						if (level == dsar_pkg::LVL_UNLOCKED && !mismatch) begin
							led = 1'b1;
							push(dsar_pkg::RESP_ROUTINE_OK, '0);
						end else begin
							push(dsar_pkg::RESP_ROUTINE_BAD, '0);
						end
					end
				end
				default: begin
					if (c == dsar_pkg::CHAR_CR) begin
						phase = dsar_pkg::PH_HEADER;
						count = '0;
						header = '0;
					end
				end
			endcase
		endfunction

		// Compares one accepted response with the oldest outstanding one.
		function void check_reply(logic [2:0] resp, logic [31:0] seed, logic led_o);
			reply_t x;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: response %0d arrived with none outstanding", $time, resp);
				return;
			end
			x = pending.pop_front();
			if (int'(x.response) < 5) seen[x.response]++;
			if (resp !== x.response) begin
				errors++;
				$display("%0t: response expected %0d actual %0d", $time, x.response, resp);
			end
			if (seed !== x.seed) begin
				errors++;
				$display("%0t: seed_out expected %h actual %h", $time, x.seed, seed);
			end
			if (led_o !== x.led) begin
				errors++;
				$display("%0t: led_on expected %0d actual %0d", $time, x.led, led_o);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  rx_char;
	logic [31:0] entropy_word;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  response;
	logic [31:0] seed_out;
	logic        led_on;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [31:0] cfg_data;

	access_scoreboard sb = new();
	int          send_idle_pct;
	int          stall_pct;
	int          hold_left;
	int          cycles;
	int          chars_sent;
	logic        pin_entropy;
	logic [31:0] pinned_entropy;

	diag_security_access_responder_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_char      (rx_char),
		.entropy_word (entropy_word),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.response     (response),
		.seed_out     (seed_out),
		.led_on       (led_on),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Run limit in case the block stops responding.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Cycle limit hit with %0d responses outstanding", sb.pending.size());
			$display("Verification failed");
			$finish;
		end
	end

	// Response side: random stalls, plus one long hold-off when requested.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Every accepted response is checked against the predicted one.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_reply(response, seed_out, led_on);
	end

	// Offers one request character and returns at the falling edge after it is taken.
	task automatic send_char(logic [7:0] c);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_char <= c;
		entropy_word <= pin_entropy ? pinned_entropy : $urandom();
		do @(posedge clk); while (in_stall);
		sb.take_char(rx_char, entropy_word);
		chars_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_char(s[i]);
	endtask

	function automatic logic [7:0] hex_char(logic [3:0] nib);
		if (nib < 4'd10) return 8'h30 + 8'(nib);
		return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
	endfunction

	function automatic logic [7:0] non_hex_char();
		logic [7:0] c;
		do c = 8'($urandom_range(255)); while (sb.hex_value(c) >= 0);
		return c;
	endfunction

	// Sends one key byte as two hex characters, or as a pair spoiled by a non-hex character.
	task automatic send_pair(logic [7:0] b, bit garbled);
		if (!garbled) begin
			send_char(hex_char(b[7:4]));
			send_char(hex_char(b[3:0]));
		end else begin
			case ($urandom_range(2))
				0: begin
					send_char(non_hex_char());
					send_char(non_hex_char());
				end
				1: begin
					send_char(non_hex_char());
					send_char(hex_char(b[3:0]));
				end
				default: begin
					send_char(hex_char(b[7:4]));
					send_char(non_hex_char());
				end
			endcase
		end
	endtask

	// Up to three trailing characters that the parser skips, then the carriage return.
	task automatic end_frame();
		int n;
		logic [7:0] c;
		n = $urandom_range(3);
		repeat (n) begin
			c = 8'($urandom_range(255));
			if (c == dsar_pkg::CHAR_CR) c = 8'h20;
			send_char(c);
		end
		send_char(dsar_pkg::CHAR_CR);
	endtask

	task automatic seed_frame();
		send_text("2701");
		end_frame();
	endtask

	// A key frame built from the predicted key; a bad one spoils exactly one byte.
	task automatic key_frame(bit good);
		logic [31:0] k;
		logic [7:0] b;
		int bad_idx;
		k = sb.key;
		bad_idx = $urandom_range(3);
		send_text("2702");
		for (int i = 0; i < 4; i++) begin
			b = k[8*(3-i) +: 8];
			if (good || i != bad_idx) send_pair(b, b == 8'h00 && $urandom_range(1) == 1);
			else if (b != 8'h00 && $urandom_range(1) == 1) send_pair(b, 1'b1);
			else send_pair(b ^ 8'($urandom_range(255, 1)), 1'b0);
		end
		end_frame();
	endtask

	task automatic routine_frame(bit good);
		logic [31:0] k;
		logic [7:0] b;
		int bad_idx;
		k = sb.routine_id;
		bad_idx = $urandom_range(3);
		send_text("3101");
		for (int i = 0; i < 4; i++) begin
			b = k[8*(3-i) +: 8];
			if (!good && i == bad_idx) b = b ^ 8'($urandom_range(255, 1));
			send_char(b);
		end
		end_frame();
	endtask

	// Headers made mostly of the digits that the real headers use.
	task automatic odd_header_frame();
		logic [7:0] digits [5];
		digits = '{8'h30, 8'h31, 8'h32, 8'h33, 8'h37};
		repeat (4) begin
			if ($urandom_range(3) != 0) send_char(digits[$urandom_range(4)]);
			else send_char(8'($urandom_range(255)));
		end
		end_frame();
	endtask

	task automatic noise_frame();
		int n;
		n = $urandom_range(12, 1);
		repeat (n) send_char(8'($urandom_range(255)));
		send_char(dsar_pkg::CHAR_CR);
	endtask

	// Mostly the frame that the access level calls for next, the rest mixed.
	task automatic random_frame(bit key_ok_allowed);
		int r;
		r = $urandom_range(99);
		if (r < 45) begin
			case (sb.level)
				dsar_pkg::LVL_LOCKED:  seed_frame();
				dsar_pkg::LVL_WAITING: key_frame(key_ok_allowed && $urandom_range(99) < 20);
				default:               routine_frame($urandom_range(3) != 0);
			endcase
		end else if (r < 58) begin
			seed_frame();
		end else if (r < 70) begin
			key_frame(key_ok_allowed && $urandom_range(1) == 1);
		end else if (r < 82) begin
			routine_frame($urandom_range(1) == 1);
		end else if (r < 91) begin
			odd_header_frame();
		end else begin
			noise_frame();
		end
	endtask

	// Writes both registers; called at a falling edge while the block is idle.
	task automatic write_regs(logic [31:0] rid, logic [7:0] addend);
		cfg_valid <= 1'b1;
		cfg_index <= dsar_pkg::CFG_ROUTINE_ID;
		cfg_data <= rid;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(dsar_pkg::CFG_ROUTINE_ID, rid);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= dsar_pkg::CFG_KEY_ADDEND;
		cfg_data <= {24'h0, addend};
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(dsar_pkg::CFG_KEY_ADDEND, {24'h0, addend});
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Stops offering requests and lets every outstanding response drain.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Reset, a directed opening, then four random phases with different idling.
	initial begin
		int target;
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_char = '0;
		entropy_word = '0;
		cfg_valid = 1'b0;
		cfg_index = dsar_pkg::CFG_ROUTINE_ID;
		cfg_data = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		chars_sent = 0;
		pin_entropy = 1'b0;
		pinned_entropy = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Seed with reset registers: the first key byte wraps to zero.
		pin_entropy = 1'b1;
		pinned_entropy = 32'hFF00_7F80;
		send_text("2701");
		send_char(dsar_pkg::CHAR_CR);
		pin_entropy = 1'b0;
		// A non-hex pair matches the zero byte, a later non-hex pair fails the key.
		send_text("2702Zz01808g");
		send_char(dsar_pkg::CHAR_CR);
		// The routine is refused while locked.
		send_text("3101AA00");
		send_char(dsar_pkg::CHAR_CR);
		settle();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
					write_regs(32'h0000_0000, 8'h00);
					hold_left = HOLD_CYCLES;
				end
				1: begin
					send_idle_pct = 60;
					stall_pct = 0;
					write_regs(32'hFFFF_FFFF, 8'hFF);
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 60;
					write_regs($urandom(), 8'($urandom_range(255)));
				end
				default: begin
					send_idle_pct = 6;
					stall_pct = 6;
					write_regs(dsar_pkg::ROUTINE_ID_RST, 8'($urandom_range(255)));
				end
			endcase
			target = chars_sent + PHASE_CHARS;
			while (chars_sent < target) random_frame(p >= 2);
			settle();
		end

		if (sb.pending.size() != 0) begin
			sb.errors += sb.pending.size();
			$display("%0t: %0d responses never arrived", $time, sb.pending.size());
		end
		$display("Sent %0d request characters over four idling phases: %0d seeds, %0d %s",
			chars_sent, sb.seen[dsar_pkg::RESP_SEED_SENT], sb.seen[dsar_pkg::RESP_KEY_OK],
			"keys accepted,");
		$display("%0d keys rejected, %0d routines started, %0d refused; LED latched %0d.",
			sb.seen[dsar_pkg::RESP_KEY_BAD], sb.seen[dsar_pkg::RESP_ROUTINE_OK],
			sb.seen[dsar_pkg::RESP_ROUTINE_BAD], sb.led);
		if (sb.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
